// ----- rtl/atvps_pkg.sv -----
// Package for the amount-to-voice-prompt sequencer: track codes, frame constants,
// microcode word layout and the microprogram ROM.
// No dependencies.
package atvps_pkg;

    localparam int INT_DIGITS = 5;
    // only four place words exist, so at most five integer places can be spoken
    localparam int PLACES     = (INT_DIGITS < 1) ? 1 : ((INT_DIGITS > 5) ? 5 : INT_DIGITS);
    localparam int NDIGITS    = PLACES + 2;
    localparam int BCD_W      = 4 * NDIGITS;
    localparam int AMT_W      = 24;
    localparam int PLACE_W    = 3;
    localparam int CNT_W      = 5;
    localparam int TRACK_W    = 5;
    localparam int PC_W       = 4;

    localparam logic [AMT_W-1:0] AMT_LIMIT = AMT_W'((10 ** PLACES) * 100 - 1);

    localparam logic [TRACK_W-1:0] TRK_TENS_WORD = 5'd10;
    localparam logic [TRACK_W-1:0] TRK_POINT     = 5'd14;
    localparam logic [TRACK_W-1:0] TRK_CURRENCY  = 5'd15;
    localparam logic [TRACK_W-1:0] TRK_PROMPT    = 5'd16;
    localparam logic [7:0]         FRAME_CMD     = 8'h41;
    localparam logic [7:0]         FRAME_LEN     = 8'h05;

    typedef enum logic [2:0] {
        OP_NOP,
        OP_LOAD,
        OP_SHIFT,
        OP_LEAD,
        OP_DEC
    } op_t;

    typedef enum logic [2:0] {
        SRC_CONST,
        SRC_DIGIT,
        SRC_WORD,
        SRC_TENTHS,
        SRC_HUND
    } src_t;

    typedef enum logic [2:0] {
        COND_NONE,
        COND_ALWAYS,
        COND_NO_INPUT,
        COND_MORE_BITS,
        COND_PLACE_ZERO,
        COND_CENTS_ZERO,
        COND_HUND_ZERO
    } cond_t;

    typedef struct packed {
        op_t                op;
        src_t               src;
        logic [TRACK_W-1:0] trk;
        logic               emit;
        logic               last;
        cond_t              cond;
        logic [PC_W-1:0]    target;
    } uword_t;

    localparam logic [PC_W-1:0] PC_IDLE    = 4'd0;
    localparam logic [PC_W-1:0] PC_CONVERT = 4'd1;
    localparam logic [PC_W-1:0] PC_PLACE   = 4'd3;
    localparam logic [PC_W-1:0] PC_UNITS   = 4'd6;
    localparam logic [PC_W-1:0] PC_CLOSE   = 4'd10;

    function automatic uword_t ucode(input logic [PC_W-1:0] pc);
        uword_t w;
        w = '{op: OP_NOP, src: SRC_CONST, trk: '0, emit: 1'b0, last: 1'b0,
              cond: COND_NONE, target: PC_IDLE};
        case (pc)
            4'd0: begin
                w.op = OP_LOAD; w.cond = COND_NO_INPUT; w.target = PC_IDLE;
            end
            4'd1: begin
                w.op = OP_SHIFT; w.cond = COND_MORE_BITS; w.target = PC_CONVERT;
            end
            4'd2: begin
                w.op = OP_LEAD; w.emit = 1'b1; w.trk = TRK_PROMPT;
            end
            4'd3: begin
                w.cond = COND_PLACE_ZERO; w.target = PC_UNITS;
            end
            4'd4: begin
                w.emit = 1'b1; w.src = SRC_DIGIT;
            end
            4'd5: begin
                w.emit = 1'b1; w.src = SRC_WORD; w.op = OP_DEC;
                w.cond = COND_ALWAYS; w.target = PC_PLACE;
            end
            4'd6: begin
                w.emit = 1'b1; w.src = SRC_DIGIT;
                w.cond = COND_CENTS_ZERO; w.target = PC_CLOSE;
            end
            4'd7: begin
                w.emit = 1'b1; w.trk = TRK_POINT;
            end
            4'd8: begin
                w.emit = 1'b1; w.src = SRC_TENTHS;
                w.cond = COND_HUND_ZERO; w.target = PC_CLOSE;
            end
            4'd9: begin
                w.emit = 1'b1; w.src = SRC_HUND;
            end
            4'd10: begin
                w.emit = 1'b1; w.trk = TRK_CURRENCY; w.last = 1'b1;
                w.cond = COND_ALWAYS; w.target = PC_IDLE;
            end
            default: begin
                w.cond = COND_ALWAYS; w.target = PC_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// ----- rtl/amount_to_voice_prompt_sequence.sv -----
// Top level of the amount-to-voice-prompt sequencer: microcoded control over a
// binary-to-BCD datapath and a registered output stage. Depends on atvps_pkg.
//
// One amount is taken at a time. After a transfer in, a shift-and-add-3 converter
// runs one bit per cycle over all 24 amount bits, then an 11-step microprogram
// emits the track commands, one per cycle when the output side keeps tready high:
// prompt, digit and place word for each place from the leading nonzero one down
// to tens (three steps per place including the loop test), units, then point,
// tenths digit and a nonzero hundredths digit when the cents are nonzero, and the
// currency track with tlast. s_tready is high only while the sequencer waits at
// its first step.
module amount_to_voice_prompt_sequence (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] amount_hundredths
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [4:0] track, [12:5] frame_check, [15:13] zero
    output logic        m_tlast
);

    logic [atvps_pkg::PC_W-1:0]    pc_reg, pc_next;
    logic [atvps_pkg::AMT_W-1:0]   bin_reg, bin_next;
    logic [atvps_pkg::BCD_W-1:0]   bcd_reg, bcd_next, bcd_adj;
    logic [atvps_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [atvps_pkg::PLACE_W-1:0] place_reg, place_next, lead;
    logic                          out_valid_reg, out_valid_next;
    logic [atvps_pkg::TRACK_W-1:0] track_reg, track_next, track_sel;
    logic                          last_reg, last_next;
    logic [3:0]                    dig_sel;
    logic [atvps_pkg::AMT_W-1:0]   amt_clamped;
    atvps_pkg::uword_t             uw;
    logic                          in_acc, stall, take;
    logic [7:0]                    frame_check;

    assign uw       = atvps_pkg::ucode(pc_reg);
    assign s_tready = (pc_reg == atvps_pkg::PC_IDLE);
    assign in_acc   = s_tvalid && s_tready;
    assign stall    = uw.emit && out_valid_reg && !m_tready;

    assign amt_clamped = (s_tdata > atvps_pkg::AMT_LIMIT) ? atvps_pkg::AMT_LIMIT : s_tdata;

    // add 3 to every BCD digit of five or more before the shift
    always_comb begin
        for (int j = 0; j < atvps_pkg::NDIGITS; j++) begin
            if (bcd_reg[4*j +: 4] >= 4'd5) begin
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4] + 4'd3;
            end else begin
                bcd_adj[4*j +: 4] = bcd_reg[4*j +: 4];
            end
        end
    end

    // leading nonzero integer place, tens and above; zero when none
    always_comb begin
        lead = '0;
        for (int p = 1; p < atvps_pkg::PLACES; p++) begin
            if (bcd_reg[8 + 4*p +: 4] != 4'd0) begin
                lead = atvps_pkg::PLACE_W'(p);
            end
        end
    end

    always_comb begin
        dig_sel = '0;
        for (int p = 0; p < atvps_pkg::PLACES; p++) begin
            if (place_reg == atvps_pkg::PLACE_W'(p)) begin
                dig_sel = bcd_reg[8 + 4*p +: 4];
            end
        end
    end

    always_comb begin
        case (uw.src)
            atvps_pkg::SRC_CONST:  track_sel = uw.trk;
            atvps_pkg::SRC_DIGIT:  track_sel = {1'b0, dig_sel};
            atvps_pkg::SRC_WORD:   track_sel = atvps_pkg::TRK_TENS_WORD - 5'd1
                                               + {2'b00, place_reg};
            atvps_pkg::SRC_TENTHS: track_sel = {1'b0, bcd_reg[7:4]};
            atvps_pkg::SRC_HUND:   track_sel = {1'b0, bcd_reg[3:0]};
            default:               track_sel = uw.trk;
        endcase
    end

    always_comb begin
        case (uw.cond)
            atvps_pkg::COND_NONE:       take = 1'b0;
            atvps_pkg::COND_ALWAYS:     take = 1'b1;
            atvps_pkg::COND_NO_INPUT:   take = !in_acc;
            atvps_pkg::COND_MORE_BITS:  take = (cnt_reg != atvps_pkg::CNT_W'(1));
            atvps_pkg::COND_PLACE_ZERO: take = (place_reg == '0);
            atvps_pkg::COND_CENTS_ZERO: take = (bcd_reg[7:0] == 8'd0);
            atvps_pkg::COND_HUND_ZERO:  take = (bcd_reg[3:0] == 4'd0);
            default:                    take = 1'b0;
        endcase
    end

    always_comb begin
        pc_next        = pc_reg;
        bin_next       = bin_reg;
        bcd_next       = bcd_reg;
        cnt_next       = cnt_reg;
        place_next     = place_reg;
        out_valid_next = out_valid_reg;
        track_next     = track_reg;
        last_next      = last_reg;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        if (!stall) begin
            pc_next = take ? uw.target : pc_reg + 4'd1;
            case (uw.op)
                atvps_pkg::OP_LOAD: begin
                    if (in_acc) begin
                        bin_next = amt_clamped;
                        bcd_next = '0;
                        cnt_next = atvps_pkg::CNT_W'(atvps_pkg::AMT_W);
                    end
                end
                atvps_pkg::OP_SHIFT: begin
                    bcd_next = {bcd_adj[atvps_pkg::BCD_W-2:0], bin_reg[atvps_pkg::AMT_W-1]};
                    bin_next = {bin_reg[atvps_pkg::AMT_W-2:0], 1'b0};
                    cnt_next = cnt_reg - 5'd1;
                end
                atvps_pkg::OP_LEAD: place_next = lead;
                atvps_pkg::OP_DEC:  place_next = place_reg - 3'd1;
                default: ;
            endcase
            if (uw.emit) begin
                out_valid_next = 1'b1;
                track_next     = track_sel;
                last_next      = uw.last;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg        <= atvps_pkg::PC_IDLE;
            out_valid_reg <= 1'b0;
        end else begin
            pc_reg        <= pc_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        bin_reg   <= bin_next;
        bcd_reg   <= bcd_next;
        cnt_reg   <= cnt_next;
        place_reg <= place_next;
        track_reg <= track_next;
        last_reg  <= last_next;
    end

    assign frame_check = atvps_pkg::FRAME_CMD ^ atvps_pkg::FRAME_LEN ^ {3'b000, track_reg};
    assign m_tvalid    = out_valid_reg;
    assign m_tdata     = {3'b000, frame_check, track_reg};
    assign m_tlast     = last_reg;

endmodule

// ----- tb/atvps_announce_checker.sv -----
`timescale 1ns / 100ps
// Scoreboard for the amount-to-voice-prompt sequencer: predicts the track commands
// for every amount transfer in and compares them with the result stream. Uses atvps_pkg.
module atvps_announce_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [23:0] s_tdata,   // [23:0] amount_hundredths
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [15:0] m_tdata,   // [4:0] track, [12:5] frame_check, [15:13] zero
    input  logic        m_tlast,
    output int          mismatch_count,
    output int          pending_count
);

    typedef struct packed {
        logic [atvps_pkg::TRACK_W-1:0] track;
        logic [7:0]                    frame_check;
        logic                          last;
    } track_cmd_t;

    track_cmd_t spoken_q[$];
    int         mismatches = 0;
    int         pending = 0;

    assign mismatch_count = mismatches;
    assign pending_count  = pending;

    function automatic void say(input logic [atvps_pkg::TRACK_W-1:0] track, input logic last);
        track_cmd_t cmd;
        cmd.track       = track;
        cmd.frame_check = atvps_pkg::FRAME_CMD ^ atvps_pkg::FRAME_LEN ^ {3'b000, track};
        cmd.last        = last;
        spoken_q.push_back(cmd);
    endfunction

    function automatic void announce_amount(input logic [23:0] amount);
        int unsigned amt;
        int unsigned whole;
        int unsigned cents;
        int unsigned scale;
        int unsigned digit [5];
        int          lead;
        int          p;
        amt   = (amount > atvps_pkg::AMT_LIMIT) ? atvps_pkg::AMT_LIMIT : amount;
        whole = amt / 100;
        cents = amt % 100;
        lead  = 0;
        scale = 1;
        for (p = 0; p < atvps_pkg::PLACES; p++) begin
            digit[p] = (whole / scale) % 10;
            if (digit[p] != 0) lead = p;
            scale = scale * 10;
        end
        say(atvps_pkg::TRK_PROMPT, 1'b0);
        // zero digits below the leading one keep their place word
        for (p = lead; p >= 1; p--) begin
            say(atvps_pkg::TRACK_W'(digit[p]), 1'b0);
            say(atvps_pkg::TRK_TENS_WORD + atvps_pkg::TRACK_W'(p - 1), 1'b0);
        end
        say(atvps_pkg::TRACK_W'(digit[0]), 1'b0);
        if (cents != 0) begin
            say(atvps_pkg::TRK_POINT, 1'b0);
            say(atvps_pkg::TRACK_W'(cents / 10), 1'b0);
            if (cents % 10 != 0) say(atvps_pkg::TRACK_W'(cents % 10), 1'b0);
        end
        say(atvps_pkg::TRK_CURRENCY, 1'b1);
    endfunction

    always @(posedge aclk) begin : watch
        track_cmd_t                    want;
        logic [atvps_pkg::TRACK_W-1:0] got_track;
        logic [7:0]                    got_frame;
        if (aresetn) begin
            if (s_tvalid && s_tready) announce_amount(s_tdata);
            if (m_tvalid && m_tready) begin
                got_track = m_tdata[4:0];
                got_frame = m_tdata[12:5];
                if (spoken_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("%0t: unexpected transfer out: track %0d check %02h last %b",
                                 $time, got_track, got_frame, m_tlast);
                end else begin
                    want = spoken_q.pop_front();
                    if (got_track !== want.track || got_frame !== want.frame_check ||
                        m_tlast !== want.last || m_tdata[15:13] !== 3'b000) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"%0t: mismatch: expected track %0d check %02h last %b,",
                                      " got track %0d check %02h last %b pad %b"},
                                     $time, want.track, want.frame_check, want.last,
                                     got_track, got_frame, m_tlast, m_tdata[15:13]);
                    end
                end
            end
            pending = spoken_q.size();
        end
    end

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// Top of the amount-to-voice-prompt sequencer testbench: clock, reset, amount
// stimulus, output back-pressure and verdict. Depends on atvps_pkg and atvps_announce_checker.
module tb_top;

    localparam int RANDOM_ITEMS   = 280;
    localparam int CALM_ITEMS     = 40;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 60;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [23:0] s_tdata;   // [23:0] amount_hundredths
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;   // [4:0] track, [12:5] frame_check, [15:13] zero
    logic        m_tlast;

    int mismatch_count;
    int pending_count;
    int quiet_cycles = 0;
    bit calm = 1'b0;

    amount_to_voice_prompt_sequence u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    atvps_announce_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_tvalid       (s_tvalid),
        .s_tready       (s_tready),
        .s_tdata        (s_tdata),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata),
        .m_tlast        (m_tlast),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // end the run if nothing moves on either side for too long
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // output back-pressure in random bursts
    initial begin
        m_tready <= 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 9)) @(posedge aclk);
            end
            m_tready <= 1'b1;
            repeat ($urandom_range(1, 20)) @(posedge aclk);
        end
    end

    task automatic send_amount(input logic [23:0] amount);
        if (!calm && $urandom_range(0, 2) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= amount;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // hold off the input until every announced track has come out
    task automatic drain_announcements();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (pending_count != 0);
        @(posedge aclk);
    endtask

    function automatic logic [23:0] pick_amount();
        int unsigned kind;
        int unsigned pw;
        int unsigned amt;
        int          k;
        kind = $urandom_range(0, 9);
        pw   = 1;
        repeat ($urandom_range(1, 5)) pw = pw * 10;
        case (kind)
            0, 1: amt = $urandom & 32'h00FF_FFFF;
            2:    amt = $urandom_range(0, pw - 1) * 100;
            3:    amt = $urandom_range(0, pw - 1) * 100 + $urandom_range(1, 9);
            4:    amt = $urandom_range(9999000, 10000100);
            5, 6: begin
                // sprinkle zero digits among nonzero ones
                amt = 0;
                for (k = 0; k < 7; k++)
                    amt = amt * 10 + (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 9));
                amt = amt % (pw * 100);
            end
            default: amt = $urandom_range(0, pw * 100 - 1);
        endcase
        return 24'(amt);
    endfunction

    logic [23:0] directed_amounts [23] = '{
        24'd0, 24'd1, 24'd9, 24'd10, 24'd50, 24'd99, 24'd100, 24'd105, 24'd110,
        24'd199, 24'd1000, 24'd10000, 24'd100000, 24'd1000000, 24'd1000001,
        24'd9090909, 24'd1234567, 24'd9999999, 24'd10000000, 24'hFFFFFF,
        24'h800000, 24'd2000050, 24'd100100
    };

    initial begin
        int i;
        aresetn  <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (i = 0; i < 23; i++) send_amount(directed_amounts[i]);
        drain_announcements();

        for (i = 0; i < RANDOM_ITEMS; i++) begin
            if (i == RANDOM_ITEMS / 2) drain_announcements();
            if (i == RANDOM_ITEMS - CALM_ITEMS) calm = 1'b1;
            send_amount(pick_amount());
        end
        s_tvalid <= 1'b0;

        do @(negedge aclk); while (pending_count != 0);
        repeat (DRAIN_CYCLES) @(negedge aclk);

        if (mismatch_count == 0 && pending_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
